/* rtl/svs_pkg.sv */
// svs_pkg: shared types, operation codes and constants of the shuttle velocity servo.
// No dependencies; imported by every module of the block.
`default_nettype none

package svs_pkg;

  localparam int unsigned CRUISE_W = 20;
  localparam int unsigned FORCE_W  = 26;
  localparam int unsigned MASS_W   = 26;
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned DT_W     = 12;
  localparam int unsigned RAD_W    = 64;   // radicand of the root unit
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned DVD_W    = 58;   // dividend of the divider
  localparam int unsigned DVS_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_CRUISE_SPEED = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_DRIVE_FORCE  = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_BODY_MASS    = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_START_PX     = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_START_PY     = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_END_PX       = 3'd5;
  localparam logic [CFG_IX_W-1:0] REG_END_PY       = 3'd6;
  localparam logic [CFG_IX_W-1:0] REG_HOLD_HEIGHT  = 3'd7;

  localparam logic [31:0]       SWITCH_DIST = 32'd13107;  // 0.2 m
  localparam logic [31:0]       STOP_DIST   = 32'd3277;   // 0.05 m
  localparam logic [DT_W-1:0]   DT_MAX      = 12'd3277;   // 0.05 s
  localparam logic [MASS_W-1:0] MASS_FLOOR  = 26'd6554;   // 0.1 kg
  localparam logic signed [15:0] Z_LIMIT    = 16'sd16384; // 0.25 m/s

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_OFFS     = 5'd2;
  localparam op_t OP_SQX      = 5'd3;
  localparam op_t OP_SQY      = 5'd4;
  localparam op_t OP_SUM      = 5'd5;
  localparam op_t OP_SQRT     = 5'd6;
  localparam op_t OP_DIST     = 5'd7;
  localparam op_t OP_TOGGLE   = 5'd8;
  localparam op_t OP_MUL_DVX  = 5'd9;
  localparam op_t OP_MUL_DVY  = 5'd10;
  localparam op_t OP_DIV_DS   = 5'd11;
  localparam op_t OP_DVX_SET  = 5'd12;
  localparam op_t OP_DVY_SET  = 5'd13;
  localparam op_t OP_MUL_STEP = 5'd14;
  localparam op_t OP_DIV_MASS = 5'd15;
  localparam op_t OP_STEP_SET = 5'd16;
  localparam op_t OP_CX2      = 5'd17;
  localparam op_t OP_CY2      = 5'd18;
  localparam op_t OP_N_SET    = 5'd19;
  localparam op_t OP_MUL_SCX  = 5'd20;
  localparam op_t OP_MUL_SCY  = 5'd21;
  localparam op_t OP_DIV_N    = 5'd22;
  localparam op_t OP_SCX_SET  = 5'd23;
  localparam op_t OP_SCY_SET  = 5'd24;
  localparam op_t OP_OUT      = 5'd25;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic lt_switch;
    logic lt_stop;
    logic scale_need;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/svs_sqrt.sv */
// svs_sqrt: integer square root, two radicand bits per cycle.
// Depends on svs_pkg.
`default_nettype none

module svs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [svs_pkg::RAD_W-1:0]  radicand,
  output logic                            busy,
  output logic                            done,
  output logic [svs_pkg::ROOT_W-1:0]      root
);
  import svs_pkg::*;

  localparam logic [4:0] LAST = 5'(ROOT_W - 1);

  logic [RAD_W-1:0]  val_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r;

  logic [ROOT_W+3:0] rem_sh, trial, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, val_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r + 5'd1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* rtl/svs_div.sv */
// svs_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on svs_pkg.
`default_nettype none

module svs_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [svs_pkg::DVD_W-1:0] dividend,
  input  wire logic [svs_pkg::DVS_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [svs_pkg::DVD_W-1:0]      quotient
);
  import svs_pkg::*;

  localparam logic [5:0] LAST = 6'(DVD_W - 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;

  logic [DVS_W:0] trial, diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/svs_datapath.sv */
// svs_datapath: configuration, tick state, shared multiplier, root and divide units,
// output register. Depends on svs_pkg, svs_sqrt, svs_div.
`default_nettype none

module svs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire svs_pkg::cmd_t                 cmd,
  output svs_pkg::sts_t                      sts,
  input  wire logic                          cfg_we,
  input  wire logic [svs_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic [31:0]                   in_tick_time,
  input  wire logic signed [31:0]            in_pos_x,
  input  wire logic signed [31:0]            in_pos_y,
  input  wire logic signed [31:0]            in_pos_z,
  input  wire logic signed [31:0]            in_vel_x,
  input  wire logic signed [31:0]            in_vel_y,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_drive_valid,
  output logic signed [31:0]                 out_cmd_vel_x,
  output logic signed [31:0]                 out_cmd_vel_y,
  output logic signed [15:0]                 out_cmd_vel_z,
  output logic                               out_toward_end,
  output logic [31:0]                        out_target_distance
);
  import svs_pkg::*;

  function automatic logic [32:0] mag33(input logic signed [32:0] a);
    mag33 = a[32] ? 33'(-a) : a;
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] a);
    mag34 = a[33] ? 34'(-a) : a;
  endfunction

  // configuration
  logic [CRUISE_W-1:0] cruise_r;
  logic [FORCE_W-1:0]  force_r;
  logic [MASS_W-1:0]   mass_r;
  logic signed [31:0]  spx_r, spy_r, epx_r, epy_r, hold_r;

  // tick state
  logic        heading_r, seen_r;
  logic [31:0] prev_r;

  // per-item working registers
  logic signed [31:0] px_r, py_r, pz_r, vx_r, vy_r;
  logic [DT_W-1:0]    dt_r;
  logic signed [32:0] ux_r, uy_r;
  logic               half_r;
  logic [63:0]        prod_r, acc_r;
  logic [ROOT_W-1:0]  ds_r, n_r;
  logic [31:0]        dist_r;
  logic signed [33:0] cx_r, cy_r;
  logic [FORCE_W-1:0] step_r;

  // output register
  logic               out_valid_r, drive_r, toward_r;
  logic signed [31:0] ovx_r, ovy_r;
  logic signed [15:0] ovz_r;
  logic [31:0]        odist_r;

  // unit handshakes
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start, div_busy, div_done;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_quo;

  // offsets toward the current target, halved when too large
  logic signed [31:0] tx, ty;
  logic signed [32:0] dx_w, dy_w;
  logic [32:0]        mdx, mdy, mux33, muy33;
  logic               half_w;
  logic [31:0]        mux_w, muy_w, mcx_w, mcy_w;
  logic [33:0]        mcx34, mcy34;

  assign tx     = heading_r ? epx_r : spx_r;
  assign ty     = heading_r ? epy_r : spy_r;
  assign dx_w   = {tx[31], tx} - {px_r[31], px_r};
  assign dy_w   = {ty[31], ty} - {py_r[31], py_r};
  assign mdx    = mag33(dx_w);
  assign mdy    = mag33(dy_w);
  assign half_w = (mdx > 33'h0_8000_0000) || (mdy > 33'h0_8000_0000);
  assign mux33  = mag33(ux_r);
  assign muy33  = mag33(uy_r);
  assign mux_w  = mux33[31:0];
  assign muy_w  = muy33[31:0];
  assign mcx34  = mag34(cx_r);
  assign mcy34  = mag34(cy_r);
  assign mcx_w  = mcx34[31:0];
  assign mcy_w  = mcy34[31:0];

  // time step of this tick
  logic signed [32:0] tdiff;
  logic [DT_W-1:0]    dt_nxt;

  assign tdiff = $signed({1'b0, in_tick_time}) - $signed({1'b0, prev_r});

  always_comb begin
    if (!seen_r || tdiff[32]) begin
      dt_nxt = '0;
    end else if (tdiff > $signed({21'd0, DT_MAX})) begin
      dt_nxt = DT_MAX;
    end else begin
      dt_nxt = tdiff[DT_W-1:0];
    end
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_SQX:      begin mul_a = mux_w; mul_b = mux_w; end
      OP_SQY:      begin mul_a = muy_w; mul_b = muy_w; end
      OP_MUL_DVX:  begin mul_a = mux_w; mul_b = {12'd0, cruise_r}; end
      OP_MUL_DVY:  begin mul_a = muy_w; mul_b = {12'd0, cruise_r}; end
      OP_MUL_STEP: begin mul_a = {6'd0, force_r}; mul_b = {20'd0, dt_r}; end
      OP_CX2:      begin mul_a = mcx_w; mul_b = mcx_w; end
      OP_CY2:      begin mul_a = mcy_w; mul_b = mcy_w; end
      OP_MUL_SCX:  begin mul_a = mcx_w; mul_b = {6'd0, step_r}; end
      OP_MUL_SCY:  begin mul_a = mcy_w; mul_b = {6'd0, step_r}; end
      default:     mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider operand selection
  logic [MASS_W-1:0] mass_eff;

  assign mass_eff   = (mass_r < MASS_FLOOR) ? MASS_FLOOR : mass_r;
  assign sqrt_start = cmd.op == OP_SQRT;
  assign div_start  = (cmd.op == OP_DIV_DS) || (cmd.op == OP_DIV_MASS) ||
                      (cmd.op == OP_DIV_N);

  always_comb begin
    case (cmd.op)
      OP_DIV_MASS: div_dvs = {6'd0, mass_eff};
      OP_DIV_N:    div_dvs = n_r;
      default:     div_dvs = ds_r;
    endcase
  end

  svs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  svs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[DVD_W-1:0]),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // derived values
  logic [32:0]        dist33;
  logic signed [33:0] dv_mag, q_mag, dvx_w, dvy_w;

  assign dist33 = half_r ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
  assign dv_mag = {13'd0, div_quo[CRUISE_W:0]};
  assign q_mag  = {2'b00, div_quo[31:0]};
  assign dvx_w  = ux_r[32] ? -dv_mag : dv_mag;
  assign dvy_w  = uy_r[32] ? -dv_mag : dv_mag;

  // output values
  logic signed [34:0] sx35, sy35, vz35;
  logic signed [32:0] dz;
  logic signed [31:0] satx, saty;
  logic signed [15:0] vz16;
  logic               drive_w;

  assign sx35 = {{3{vx_r[31]}}, vx_r} + {cx_r[33], cx_r};
  assign sy35 = {{3{vy_r[31]}}, vy_r} + {cy_r[33], cy_r};
  assign dz   = {hold_r[31], hold_r} - {pz_r[31], pz_r};
  assign vz35 = {dz, 2'b00};

  always_comb begin
    if (sx35[34:31] == 4'b0000 || sx35[34:31] == 4'b1111) satx = sx35[31:0];
    else if (sx35[34]) satx = 32'sh8000_0000;
    else satx = 32'sh7FFF_FFFF;
    if (sy35[34:31] == 4'b0000 || sy35[34:31] == 4'b1111) saty = sy35[31:0];
    else if (sy35[34]) saty = 32'sh8000_0000;
    else saty = 32'sh7FFF_FFFF;
    if (vz35 > 35'(Z_LIMIT)) vz16 = Z_LIMIT;
    else if (vz35 < -35'(Z_LIMIT)) vz16 = -Z_LIMIT;
    else vz16 = vz35[15:0];
  end

  assign drive_w = !sts.lt_stop;

  // control state: configuration, heading, time, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_r    <= 20'd32768;
      force_r     <= 26'd655360;
      mass_r      <= 26'd65536;
      spx_r       <= '0;
      spy_r       <= '0;
      epx_r       <= 32'sd327680;
      epy_r       <= '0;
      hold_r      <= '0;
      heading_r   <= 1'b1;
      seen_r      <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRUISE_SPEED: cruise_r <= cfg_data[CRUISE_W-1:0];
          REG_DRIVE_FORCE:  force_r  <= cfg_data[FORCE_W-1:0];
          REG_BODY_MASS:    mass_r   <= cfg_data[MASS_W-1:0];
          REG_START_PX:     spx_r    <= cfg_data;
          REG_START_PY:     spy_r    <= cfg_data;
          REG_END_PX:       epx_r    <= cfg_data;
          REG_END_PY:       epy_r    <= cfg_data;
          REG_HOLD_HEIGHT:  hold_r   <= cfg_data;
          default:          ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        prev_r <= in_tick_time;
        seen_r <= 1'b1;
      end
      if (cmd.op == OP_TOGGLE) begin
        heading_r <= !heading_r;
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    case (cmd.op)
      OP_LOAD: begin
        px_r <= in_pos_x;
        py_r <= in_pos_y;
        pz_r <= in_pos_z;
        vx_r <= in_vel_x;
        vy_r <= in_vel_y;
        dt_r <= dt_nxt;
      end
      OP_OFFS: begin
        half_r <= half_w;
        ux_r   <= half_w ? (dx_w >>> 1) : dx_w;
        uy_r   <= half_w ? (dy_w >>> 1) : dy_w;
      end
      OP_SQY, OP_CY2: acc_r <= prod_r;
      OP_SUM:         acc_r <= acc_r + prod_r;
      OP_DIST: begin
        ds_r   <= sqrt_root;
        dist_r <= dist33[32] ? 32'hFFFF_FFFF : dist33[31:0];
      end
      OP_DVX_SET:  cx_r   <= dvx_w - {{2{vx_r[31]}}, vx_r};
      OP_DVY_SET:  cy_r   <= dvy_w - {{2{vy_r[31]}}, vy_r};
      OP_STEP_SET: step_r <= div_quo[FORCE_W-1:0];
      OP_N_SET:    n_r    <= sqrt_root;
      OP_SCX_SET:  cx_r   <= cx_r[33] ? -q_mag : q_mag;
      OP_SCY_SET:  cy_r   <= cy_r[33] ? -q_mag : q_mag;
      OP_OUT: begin
        drive_r  <= drive_w;
        ovx_r    <= drive_w ? satx : '0;
        ovy_r    <= drive_w ? saty : '0;
        ovz_r    <= drive_w ? vz16 : '0;
        toward_r <= heading_r;
        odist_r  <= dist_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.sqrt_done  = sqrt_done;
    sts.div_done   = div_done;
    sts.lt_switch  = dist_r < SWITCH_DIST;
    sts.lt_stop    = dist_r < STOP_DIST;
    sts.scale_need = (n_r > {6'd0, step_r}) && (n_r != '0);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_drive_valid     = drive_r;
  assign out_cmd_vel_x       = ovx_r;
  assign out_cmd_vel_y       = ovy_r;
  assign out_cmd_vel_z       = ovz_r;
  assign out_toward_end      = toward_r;
  assign out_target_distance = odist_r;

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy) else $error("root unit started while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_OUT))
    else $error("result appeared without an output load");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !drive_r) |-> (ovx_r == 0 && ovy_r == 0 && ovz_r == 0))
    else $error("velocity command present without drive");

endmodule

`default_nettype wire

/* rtl/svs_ctrl.sv */
// svs_ctrl: sequencer that steps the datapath through one tick.
// Depends on svs_pkg.
`default_nettype none

module svs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output svs_pkg::cmd_t      cmd,
  input  wire svs_pkg::sts_t sts
);
  import svs_pkg::*;

  localparam logic [5:0] ST_IDLE   = 6'd0;
  localparam logic [5:0] ST_OFFS   = 6'd1;
  localparam logic [5:0] ST_SQX    = 6'd2;
  localparam logic [5:0] ST_SQY    = 6'd3;
  localparam logic [5:0] ST_SUM    = 6'd4;
  localparam logic [5:0] ST_SQRT   = 6'd5;
  localparam logic [5:0] ST_SQRT_W = 6'd6;
  localparam logic [5:0] ST_DIST   = 6'd7;
  localparam logic [5:0] ST_CHECK  = 6'd8;
  localparam logic [5:0] ST_DVX_M  = 6'd9;
  localparam logic [5:0] ST_DVX_D  = 6'd10;
  localparam logic [5:0] ST_DVX_W  = 6'd11;
  localparam logic [5:0] ST_DVX_S  = 6'd12;
  localparam logic [5:0] ST_DVY_M  = 6'd13;
  localparam logic [5:0] ST_DVY_D  = 6'd14;
  localparam logic [5:0] ST_DVY_W  = 6'd15;
  localparam logic [5:0] ST_DVY_S  = 6'd16;
  localparam logic [5:0] ST_STP_M  = 6'd17;
  localparam logic [5:0] ST_STP_D  = 6'd18;
  localparam logic [5:0] ST_STP_W  = 6'd19;
  localparam logic [5:0] ST_STP_S  = 6'd20;
  localparam logic [5:0] ST_CX2    = 6'd21;
  localparam logic [5:0] ST_CY2    = 6'd22;
  localparam logic [5:0] ST_SUM2   = 6'd23;
  localparam logic [5:0] ST_NRT    = 6'd24;
  localparam logic [5:0] ST_NRT_W  = 6'd25;
  localparam logic [5:0] ST_N_S    = 6'd26;
  localparam logic [5:0] ST_SC_CHK = 6'd27;
  localparam logic [5:0] ST_SCX_M  = 6'd28;
  localparam logic [5:0] ST_SCX_D  = 6'd29;
  localparam logic [5:0] ST_SCX_W  = 6'd30;
  localparam logic [5:0] ST_SCX_S  = 6'd31;
  localparam logic [5:0] ST_SCY_M  = 6'd32;
  localparam logic [5:0] ST_SCY_D  = 6'd33;
  localparam logic [5:0] ST_SCY_W  = 6'd34;
  localparam logic [5:0] ST_SCY_S  = 6'd35;
  localparam logic [5:0] ST_OUT    = 6'd36;

  logic [5:0] state_r, state_nxt;
  logic       switched_r, switched_nxt;

  always_comb begin
    state_nxt    = state_r;
    switched_nxt = switched_r;
    cmd.op       = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op       = OP_LOAD;
          switched_nxt = 1'b0;
          state_nxt    = ST_OFFS;
        end
      end
      ST_OFFS:   begin cmd.op = OP_OFFS; state_nxt = ST_SQX; end
      ST_SQX:    begin cmd.op = OP_SQX;  state_nxt = ST_SQY; end
      ST_SQY:    begin cmd.op = OP_SQY;  state_nxt = ST_SUM; end
      ST_SUM:    begin cmd.op = OP_SUM;  state_nxt = ST_SQRT; end
      ST_SQRT:   begin cmd.op = OP_SQRT; state_nxt = ST_SQRT_W; end
      ST_SQRT_W: if (sts.sqrt_done) state_nxt = ST_DIST;
      ST_DIST:   begin cmd.op = OP_DIST; state_nxt = ST_CHECK; end
      ST_CHECK: begin
        if (sts.lt_switch && !switched_r) begin
          cmd.op       = OP_TOGGLE;
          switched_nxt = 1'b1;
          state_nxt    = ST_OFFS;
        end else if (sts.lt_stop) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DVX_M;
        end
      end
      ST_DVX_M:  begin cmd.op = OP_MUL_DVX;  state_nxt = ST_DVX_D; end
      ST_DVX_D:  begin cmd.op = OP_DIV_DS;   state_nxt = ST_DVX_W; end
      ST_DVX_W:  if (sts.div_done) state_nxt = ST_DVX_S;
      ST_DVX_S:  begin cmd.op = OP_DVX_SET;  state_nxt = ST_DVY_M; end
      ST_DVY_M:  begin cmd.op = OP_MUL_DVY;  state_nxt = ST_DVY_D; end
      ST_DVY_D:  begin cmd.op = OP_DIV_DS;   state_nxt = ST_DVY_W; end
      ST_DVY_W:  if (sts.div_done) state_nxt = ST_DVY_S;
      ST_DVY_S:  begin cmd.op = OP_DVY_SET;  state_nxt = ST_STP_M; end
      ST_STP_M:  begin cmd.op = OP_MUL_STEP; state_nxt = ST_STP_D; end
      ST_STP_D:  begin cmd.op = OP_DIV_MASS; state_nxt = ST_STP_W; end
      ST_STP_W:  if (sts.div_done) state_nxt = ST_STP_S;
      ST_STP_S:  begin cmd.op = OP_STEP_SET; state_nxt = ST_CX2; end
      ST_CX2:    begin cmd.op = OP_CX2;      state_nxt = ST_CY2; end
      ST_CY2:    begin cmd.op = OP_CY2;      state_nxt = ST_SUM2; end
      ST_SUM2:   begin cmd.op = OP_SUM;      state_nxt = ST_NRT; end
      ST_NRT:    begin cmd.op = OP_SQRT;     state_nxt = ST_NRT_W; end
      ST_NRT_W:  if (sts.sqrt_done) state_nxt = ST_N_S;
      ST_N_S:    begin cmd.op = OP_N_SET;    state_nxt = ST_SC_CHK; end
      ST_SC_CHK: state_nxt = sts.scale_need ? ST_SCX_M : ST_OUT;
      ST_SCX_M:  begin cmd.op = OP_MUL_SCX;  state_nxt = ST_SCX_D; end
      ST_SCX_D:  begin cmd.op = OP_DIV_N;    state_nxt = ST_SCX_W; end
      ST_SCX_W:  if (sts.div_done) state_nxt = ST_SCX_S;
      ST_SCX_S:  begin cmd.op = OP_SCX_SET;  state_nxt = ST_SCY_M; end
      ST_SCY_M:  begin cmd.op = OP_MUL_SCY;  state_nxt = ST_SCY_D; end
      ST_SCY_D:  begin cmd.op = OP_DIV_N;    state_nxt = ST_SCY_W; end
      ST_SCY_W:  if (sts.div_done) state_nxt = ST_SCY_S;
      ST_SCY_S:  begin cmd.op = OP_SCY_SET;  state_nxt = ST_OUT; end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      switched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      switched_r <= switched_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> sts.out_free) else $error("result loaded over a waiting one");

  a_one_switch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_TOGGLE |-> !switched_r) else $error("second target switch in one tick");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |=> state_r == ST_OFFS) else $error("item load did not start a tick");

endmodule

`default_nettype wire

/* rtl/shuttle_velocity_servo.sv */
// shuttle_velocity_servo: top level of the shuttle velocity servo.
// Depends on svs_pkg, svs_ctrl, svs_datapath (with svs_sqrt, svs_div).
//
// Use:
//   One input item per physics tick (time, position, planar velocity) on the
//   in_ channel; one result item per input item on the out_ channel. Both use
//   valid/stall: an item moves on a rising edge with valid high and stall low.
//   Registers are written through cfg_ (index, data), always ready; write them
//   only while the block is idle.
// Sequencing:
//   One item at a time. The result is loaded after one distance root when the
//   tick ends near the target, after a second one when it also switched target,
//   and after further multiplies, divides and a root when it drives. The next
//   item is taken the cycle after that load. The work is paced by the shared
//   32-step root unit (up to three roots) and the shared 58-step divider (up
//   to five divides).
// Reset (rst_n low, synchronous): registers take their defaults, heading is
//   toward the end point, no tick has been seen, no result is pending.
// Stall: a finished result waits in the output register; the next item is
//   accepted and worked on meanwhile, and waits only at its own output load.
`default_nettype none

module shuttle_velocity_servo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [31:0]                   in_tick_time,
  input  wire logic signed [31:0]            in_pos_x,
  input  wire logic signed [31:0]            in_pos_y,
  input  wire logic signed [31:0]            in_pos_z,
  input  wire logic signed [31:0]            in_vel_x,
  input  wire logic signed [31:0]            in_vel_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_drive_valid,
  output logic signed [31:0]                 out_cmd_vel_x,
  output logic signed [31:0]                 out_cmd_vel_y,
  output logic signed [15:0]                 out_cmd_vel_z,
  output logic                               out_toward_end,
  output logic [31:0]                        out_target_distance,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [svs_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import svs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes never wait
  assign cfg_ready = 1'b1;

  svs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  svs_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_tick_time        (in_tick_time),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_vel_x            (in_vel_x),
    .in_vel_y            (in_vel_y),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_drive_valid     (out_drive_valid),
    .out_cmd_vel_x       (out_cmd_vel_x),
    .out_cmd_vel_y       (out_cmd_vel_y),
    .out_cmd_vel_z       (out_cmd_vel_z),
    .out_toward_end      (out_toward_end),
    .out_target_distance (out_target_distance)
  );

endmodule

`default_nettype wire

/* dv/svs_checker.sv */
// svs_checker: watches the in_, out_ and cfg_ channels of shuttle_velocity_servo,
// predicts every result item and compares it field by field.
// Depends on svs_pkg for the register indexes and thresholds.
`default_nettype none

module svs_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [31:0]                  in_tick_time,
  input  wire logic signed [31:0]           in_pos_x,
  input  wire logic signed [31:0]           in_pos_y,
  input  wire logic signed [31:0]           in_pos_z,
  input  wire logic signed [31:0]           in_vel_x,
  input  wire logic signed [31:0]           in_vel_y,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic                         out_drive_valid,
  input  wire logic signed [31:0]           out_cmd_vel_x,
  input  wire logic signed [31:0]           out_cmd_vel_y,
  input  wire logic signed [15:0]           out_cmd_vel_z,
  input  wire logic                         out_toward_end,
  input  wire logic [31:0]                  out_target_distance,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [svs_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import svs_pkg::*;

  typedef struct packed {
    logic               drive_valid;
    logic signed [31:0] cmd_vel_x;
    logic signed [31:0] cmd_vel_y;
    logic signed [15:0] cmd_vel_z;
    logic               toward_end;
    logic [31:0]        target_distance;
  } servo_cmd_t;

  servo_cmd_t cmd_q[$];

  logic [CRUISE_W-1:0] cruise;
  logic [FORCE_W-1:0]  force_lim;
  logic [MASS_W-1:0]   mass_reg;
  logic signed [31:0]  sx, sy, ex, ey, hold_z;
  logic                to_end;
  logic [31:0]         last_t;
  logic                had_tick;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(longint a);
    return (a < 0) ? longint'(-a) : longint'(a);
  endfunction

  function automatic longint scale(longint a, longint unsigned b, longint unsigned c);
    longint unsigned q;
    q = absv(a) * b / c;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // distance to target; huge offsets are halved, rooted, then doubled
  function automatic longint unsigned range_to(longint dx, longint dy,
                                               output longint ux, output longint uy,
                                               output longint unsigned rt);
    bit halve;
    longint unsigned d;
    halve = absv(dx) > 64'd2147483648 || absv(dy) > 64'd2147483648;
    if (halve) begin
      dx = dx >>> 1;
      dy = dy >>> 1;
    end
    rt = root64(absv(dx) * absv(dx) + absv(dy) * absv(dy));
    ux = dx;
    uy = dy;
    d = halve ? rt * 2 : rt;
    return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
  endfunction

  function automatic longint tgt_x(logic e);
    return e ? longint'(ex) : longint'(sx);
  endfunction

  function automatic longint tgt_y(logic e);
    return e ? longint'(ey) : longint'(sy);
  endfunction

  task automatic predict_servo_cmd();
    longint dt, ux, uy, dvx, dvy, cx, cy, vz;
    longint unsigned range_d, rt, m, stp, n;
    servo_cmd_t c;
    dt = 0;
    if (had_tick) begin
      dt = longint'({32'd0, in_tick_time}) - longint'({32'd0, last_t});
      if (dt < 0) dt = 0;
      if (dt > DT_MAX) dt = DT_MAX;
    end
    last_t   = in_tick_time;
    had_tick = 1'b1;
    range_d = range_to(tgt_x(to_end) - in_pos_x, tgt_y(to_end) - in_pos_y, ux, uy, rt);
    if (range_d < SWITCH_DIST) begin
      to_end = !to_end;
      range_d = range_to(tgt_x(to_end) - in_pos_x, tgt_y(to_end) - in_pos_y, ux, uy, rt);
    end
    c = '0;
    c.toward_end      = to_end;
    c.target_distance = range_d[31:0];
    if (range_d >= STOP_DIST) begin
      dvx = scale(ux, cruise, rt);
      dvy = scale(uy, cruise, rt);
      cx  = dvx - in_vel_x;
      cy  = dvy - in_vel_y;
      m   = (mass_reg < MASS_FLOOR) ? MASS_FLOOR : mass_reg;
      stp = longint'(force_lim) * longint'(dt) / m;
      n   = root64(absv(cx) * absv(cx) + absv(cy) * absv(cy));
      if (n > stp && n >= 1) begin
        cx = scale(cx, stp, n);
        cy = scale(cy, stp, n);
      end
      vz = (longint'(hold_z) - longint'(in_pos_z)) * 4;
      if (vz > Z_LIMIT) vz = Z_LIMIT;
      if (vz < -Z_LIMIT) vz = -Z_LIMIT;
      c.drive_valid = 1'b1;
      c.cmd_vel_x   = 32'(sat32(longint'(in_vel_x) + cx));
      c.cmd_vel_y   = 32'(sat32(longint'(in_vel_y) + cy));
      c.cmd_vel_z   = vz[15:0];
    end
    cmd_q.push_back(c);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    servo_cmd_t w;
    if (!rst_n) begin
      cruise = 20'd32768; force_lim = 26'd655360; mass_reg = 26'd65536;
      sx = 0; sy = 0; ex = 32'sd327680; ey = 0; hold_z = 0;
      to_end = 1'b1; last_t = 0; had_tick = 1'b0;
      fail_count = 0;
      cmd_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          report("unexpected result", out_target_distance, 0);
        end else begin
          w = cmd_q.pop_front();
          if (out_drive_valid != w.drive_valid)
            report("drive_valid", out_drive_valid, w.drive_valid);
          if (out_cmd_vel_x != w.cmd_vel_x) report("cmd_vel_x", out_cmd_vel_x, w.cmd_vel_x);
          if (out_cmd_vel_y != w.cmd_vel_y) report("cmd_vel_y", out_cmd_vel_y, w.cmd_vel_y);
          if (out_cmd_vel_z != w.cmd_vel_z) report("cmd_vel_z", out_cmd_vel_z, w.cmd_vel_z);
          if (out_toward_end != w.toward_end)
            report("toward_end", out_toward_end, w.toward_end);
          if (out_target_distance != w.target_distance)
            report("target_distance", out_target_distance, w.target_distance);
        end
      end
      if (in_valid && !in_stall) predict_servo_cmd();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRUISE_SPEED: cruise    = cfg_data[CRUISE_W-1:0];
          REG_DRIVE_FORCE:  force_lim = cfg_data[FORCE_W-1:0];
          REG_BODY_MASS:    mass_reg  = cfg_data[MASS_W-1:0];
          REG_START_PX:     sx        = cfg_data;
          REG_START_PY:     sy        = cfg_data;
          REG_END_PX:       ex        = cfg_data;
          REG_END_PY:       ey        = cfg_data;
          REG_HOLD_HEIGHT:  hold_z    = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= cmd_q.size();
  end

endmodule

`default_nettype wire

/* dv/tb_shuttle_velocity_servo.sv */
// tb_shuttle_velocity_servo: stimulus and verdict for shuttle_velocity_servo.
// Depends on svs_pkg, the block's RTL and svs_checker (prediction and compare).
`default_nettype none

module tb_shuttle_velocity_servo;
  import svs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_tick_time = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_drive_valid;
  logic signed [31:0] out_cmd_vel_x, out_cmd_vel_y;
  logic signed [15:0] out_cmd_vel_z;
  logic out_toward_end;
  logic [31:0] out_target_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;

  // shadow of the shuttle points, used to aim stimulus at the targets
  logic signed [31:0] pt_sx = 0, pt_sy = 0, pt_ex = 32'sd327680, pt_ey = 0;
  logic [31:0] now_t = 0;
  bit calm = 1'b0;  // set during the stretch without any idling

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shuttle_velocity_servo uut (.*);

  svs_checker chk (.*);

  // receiver back-pressure: about a quarter of cycles stalled, none while calm
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // hard stop well past the slowest legal run
  initial begin
    #80_000_000;
    $display("shuttle_velocity_servo regression: fail");
    $finish;
  end

  // cfg_valid drops after each write, which keeps back to back writes apart
  task automatic reg_write(logic [CFG_IX_W-1:0] ix, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_points(logic signed [31:0] ax, ay, bx, by);
    reg_write(REG_START_PX, ax);
    reg_write(REG_START_PY, ay);
    reg_write(REG_END_PX, bx);
    reg_write(REG_END_PY, by);
    pt_sx = ax; pt_sy = ay; pt_ex = bx; pt_ey = by;
  endtask

  // valid stays high after acceptance unless this task idles at random or drain() lowers it
  task automatic send_tick(logic [31:0] t, logic signed [31:0] px, py, pz, vx, vy);
    in_valid     <= 1'b1;
    in_tick_time <= t;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_pos_z     <= pz;
    in_vel_x     <= vx;
    in_vel_y     <= vy;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait for every expected item, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_wide();
    return $urandom();
  endfunction

  // mostly tame values, sometimes anything at all
  function automatic logic signed [31:0] rnd_len(int span);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic rnd_config();
    case ($urandom_range(0, 3))
      0: reg_write(REG_CRUISE_SPEED, 0);
      1: reg_write(REG_CRUISE_SPEED, 655360);
      default: reg_write(REG_CRUISE_SPEED, $urandom_range(0, 655360));
    endcase
    case ($urandom_range(0, 3))
      0: reg_write(REG_DRIVE_FORCE, 0);
      1: reg_write(REG_DRIVE_FORCE, 65536000);
      default: reg_write(REG_DRIVE_FORCE, $urandom_range(0, 65536000));
    endcase
    case ($urandom_range(0, 4))
      0: reg_write(REG_BODY_MASS, $urandom_range(0, 6554));
      1: reg_write(REG_BODY_MASS, 65536000);
      2: reg_write(REG_BODY_MASS, 26'h3FF_FFFF);
      default: reg_write(REG_BODY_MASS, $urandom_range(6554, 65536000));
    endcase
    if ($urandom_range(0, 4) == 0)
      set_points(rnd_wide(), rnd_wide(), rnd_wide(), rnd_wide());
    else
      set_points(rnd_len(655360), rnd_len(655360), rnd_len(655360), rnd_len(655360));
    reg_write(REG_HOLD_HEIGHT, rnd_len(65536));
  endtask

  // one random tick, mostly along a shuttle run with plausible timing
  task automatic rnd_tick();
    logic signed [31:0] px, py;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) now_t = now_t - $urandom_range(0, 5000);
    else if (r < 14) now_t = rnd_wide();
    else now_t = now_t + $urandom_range(0, 4000);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      px = pt_ex + rnd_len(16000); py = pt_ey + rnd_len(16000);
    end else if (r < 60) begin
      px = pt_sx + rnd_len(16000); py = pt_sy + rnd_len(16000);
    end else if (r < 90) begin
      px = pt_sx + (pt_ex - pt_sx) / 2 + rnd_len(200000);
      py = pt_sy + (pt_ey - pt_sy) / 2 + rnd_len(200000);
    end else begin
      px = rnd_wide(); py = rnd_wide();
    end
    send_tick(now_t, px, py, rnd_len(100000), rnd_len(70000), rnd_len(70000));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: first tick far from the end point, no correction yet
    send_tick(32'd100, 0, 0, 0, 0, 0);
    send_tick(32'd1100, 0, 0, 32'sd5000, 32'sd1000, -32'sd1000);
    // time running backwards, then a jump longer than the dt bound
    send_tick(32'd50, 32'sd65536, 0, 0, 0, 0);
    send_tick(32'd200000, 32'sd65536, 32'sd100, 0, 0, 0);
    // arrival at the end point toggles the target to the start
    send_tick(32'd201000, 32'sd327680, 0, 0, 32'sd32768, 0);
    send_tick(32'd202000, 32'sd327000, 32'sd500, 0, 0, 0);
    send_tick(32'd203000, 32'sd1000, -32'sd1000, 0, -32'sd32768, 0);
    send_tick(32'd204000, 0, 0, 0, 0, 0);
    drain();

    // both points together: switch and stop on one tick; height extremes
    set_points(32'sd1000, -32'sd1000, 32'sd1000, -32'sd1000);
    reg_write(REG_HOLD_HEIGHT, 32'h7FFF_FFFF);
    send_tick(32'd205000, 32'sd1000, -32'sd1000, 32'sh8000_0000, 0, 0);
    send_tick(32'd206000, 32'sd3000, -32'sd2000, 32'sh7FFF_FFFF, 0, 0);
    send_tick(32'd207000, 32'sd200000, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // huge offsets, saturating velocities, strongest drive and lightest body
    set_points(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    reg_write(REG_CRUISE_SPEED, 655360);
    reg_write(REG_DRIVE_FORCE, 65536000);
    reg_write(REG_BODY_MASS, 0);
    reg_write(REG_HOLD_HEIGHT, 32'h8000_0000);
    send_tick(32'hFFFF_F000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_tick(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
              32'sh8000_0000, 32'sh8000_0000);
    send_tick(32'h0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
    send_tick(32'hFFFF_FFFF, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_tick(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
    drain();

    // random phases under varied settings, one of them without idling
    for (int ph = 0; ph < 7; ph++) begin
      rnd_config();
      calm = (ph == 3);
      for (int k = 0; k < 220; k++) begin
        rnd_tick();
        if (k == 110 && ph == 1) drain();  // sender holds off until caught up
      end
      drain();
      calm = 1'b0;
    end

    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("shuttle_velocity_servo regression: pass");
    else
      $display("shuttle_velocity_servo regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
